>>> rtl/core/bit_vector_set_engine_core_assert.svh
// Assertion macros for the bit vector set engine core.
`ifndef BIT_VECTOR_SET_ENGINE_CORE_ASSERT_SVH
`define BIT_VECTOR_SET_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BVES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BVES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bves_pkg.sv
// Shared types and constants for the bit vector set engine.
package bves_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam int SLOT_COUNT       = 256;
    localparam int OP_W             = 4;
    localparam int POS_W            = 8;
    localparam int POP_W            = 9;

    typedef enum logic [OP_W-1:0] {
        OP_SET      = 4'd0,
        OP_CLEAR    = 4'd1,
        OP_TEST     = 4'd2,
        OP_FIRST    = 4'd3,
        OP_LAST     = 4'd4,
        OP_NEXT     = 4'd5,
        OP_COUNT    = 4'd6,
        OP_RANGE    = 4'd7,
        OP_CLEARALL = 4'd8,
        OP_INVERT   = 4'd9
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] range_end;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] found_position;
        logic [POP_W-1:0] population;
        logic             error;
    } result_t;

endpackage

>>> rtl/core/bves_pipe_reg.sv
// One valid/ready register stage holding a packed beat.
module bves_pipe_reg
    import bves_pkg::*;
#(
    parameter int W = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         valid_reg;
    logic         valid_next;
    logic [W-1:0] data_reg;
    logic         take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/bves_exec.sv
// Bit vector register, its update logic and the query result logic.
module bves_exec
    import bves_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  logic    fire,
    output result_t result
);

`include "bit_vector_set_engine_core_assert.svh"

    localparam int LIMIT = (CAPACITY < SLOT_COUNT) ? CAPACITY : SLOT_COUNT;
    localparam logic [POS_W:0] LIMIT_V = (POS_W + 1)'(LIMIT);

    op_t              op;
    logic             pos_in;
    logic [LIMIT-1:0] member_reg;
    logic [LIMIT-1:0] member_next;
    logic [LIMIT-1:0] sel_mask;
    logic [LIMIT-1:0] above_mask;
    logic [LIMIT-1:0] range_mask;
    logic [LIMIT-1:0] prefix_mask;
    logic [LIMIT-1:0] above_bits;
    logic             first_hit;
    logic [POS_W-1:0] first_pos;
    logic             last_hit;
    logic [POS_W-1:0] high_pos;
    logic             next_hit;
    logic [POS_W-1:0] next_pos;
    logic [POP_W-1:0] pop;

    assign op     = op_t'(req.opcode);
    assign pos_in = {1'b0, req.position} < LIMIT_V;

    always_comb
    begin
        for (int i = 0; i < LIMIT; i++)
        begin
            sel_mask[i]    = POS_W'(i) == req.position;
            above_mask[i]  = POS_W'(i) > req.position;
            range_mask[i]  = (POS_W'(i) >= req.position) && (POS_W'(i) <= req.range_end);
            prefix_mask[i] = POS_W'(i) <= req.position;
        end
    end

    assign above_bits = member_reg & above_mask;

    // priority encoders: lowest wins for first/next, highest for last
    always_comb
    begin
        first_hit = 1'b0;
        first_pos = '0;
        next_hit  = 1'b0;
        next_pos  = '0;
        for (int i = LIMIT - 1; i >= 0; i--)
        begin
            if (member_reg[i])
            begin
                first_hit = 1'b1;
                first_pos = POS_W'(i);
            end
            if (above_bits[i])
            begin
                next_hit = 1'b1;
                next_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        last_hit = 1'b0;
        high_pos = '0;
        for (int i = 0; i < LIMIT; i++)
        begin
            if (member_reg[i])
            begin
                last_hit = 1'b1;
                high_pos = POS_W'(i);
            end
        end
    end

    assign pop = POP_W'($countones(member_reg));

    always_comb
    begin
        member_next = member_reg;
        result      = '0;
        unique case (op)
            OP_SET:
            begin
                member_next  = member_reg | sel_mask;
                result.error = !pos_in;
            end
            OP_CLEAR:
            begin
                member_next = member_reg & ~sel_mask;
            end
            OP_TEST:
            begin
                result.found = |(member_reg & sel_mask);
            end
            OP_FIRST:
            begin
                result.found          = first_hit;
                result.found_position = first_pos;
            end
            OP_LAST:
            begin
                result.found          = last_hit;
                result.found_position = high_pos;
            end
            OP_NEXT:
            begin
                result.found          = next_hit;
                result.found_position = next_pos;
            end
            OP_COUNT:
            begin
                result.population = pop;
            end
            OP_RANGE:
            begin
                result.found = |(member_reg & range_mask);
            end
            OP_CLEARALL:
            begin
                member_next = '0;
            end
            OP_INVERT:
            begin
                if (pos_in)
                begin
                    member_next = member_reg ^ prefix_mask;
                end
                result.error = !pos_in;
            end
            default:
            begin
                member_next = member_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= '0;
        end
        else if (fire)
        begin
            member_reg <= member_next;
        end
    end

    `BVES_ASSERT_NOW(a_err_op, result.error, op == OP_SET || op == OP_INVERT, "error on wrong op")
    `BVES_ASSERT_NOW(a_pop_op, result.population != '0, op == OP_COUNT, "population leak")
    `BVES_ASSERT_NOW(a_fpos_found, result.found_position != '0, result.found, "stray position")
    `BVES_ASSERT_NEXT(a_clearall, fire && op == OP_CLEARALL, member_reg == '0, "clearall missed")

endmodule

>>> rtl/core/bit_vector_set_engine_core.sv
// Top level of the bit vector set engine: request stage, execute logic, response stage.
//
//  channel | handshake            | beat fields
//  --------+----------------------+----------------------------------------------
//  req     | req_valid/req_ready  | opcode, position, range_end
//  rsp     | rsp_valid/rsp_ready  | found, found_position, population, error
//
// One request per cycle unless rsp_ready stalls; rsp_valid rises as a beat enters rsp_q.
// Execute logic runs between the request register and the response register,
// reading and updating the bit vector register in the same cycle.
// rst_n clears the bit vector and both stage valid flags.
// A stalled response holds the request stage; the bit vector updates only as
// a request moves into the response register.
module bit_vector_set_engine_core
    import bves_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [OP_W-1:0]  opcode,
    input  logic [POS_W-1:0] position,
    input  logic [POS_W-1:0] range_end,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic             found,
    output logic [POS_W-1:0] found_position,
    output logic [POP_W-1:0] population,
    output logic             error
);

    req_t    req_in;
    req_t    req_q;
    logic    req_q_valid;
    logic    exec_ready;
    logic    fire;
    result_t result;
    result_t rsp_q;

    assign req_in.opcode    = opcode;
    assign req_in.position  = position;
    assign req_in.range_end = range_end;

    bves_pipe_reg #(
        .W ($bits(req_t))
    ) u_req_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req_in),
        .out_valid (req_q_valid),
        .out_ready (exec_ready),
        .out_data  (req_q)
    );

    assign fire = req_q_valid && exec_ready;

    bves_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_q),
        .fire   (fire),
        .result (result)
    );

    bves_pipe_reg #(
        .W ($bits(result_t))
    ) u_rsp_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_q_valid),
        .in_ready  (exec_ready),
        .in_data   (result),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp_q)
    );

    assign found          = rsp_q.found;
    assign found_position = rsp_q.found_position;
    assign population     = rsp_q.population;
    assign error          = rsp_q.error;

endmodule

>>> sim/tb_bit_vector_set_engine_core.sv
// Self-checking testbench for bit_vector_set_engine_core with a bit-accurate bitset predictor.
`timescale 1ns / 100ps

module tb_bit_vector_set_engine_core
    import bves_pkg::*;
;

    localparam int SPAN       = (DEFAULT_CAPACITY < SLOT_COUNT) ? DEFAULT_CAPACITY : SLOT_COUNT;
    localparam int OP_TOP     = (1 << OP_W) - 1;
    localparam int POS_TOP    = (1 << POS_W) - 1;
    localparam int RANDOM_REQ = 1600;
    localparam int REPORT_MAX = 10;

    class bitset_tracker;
        logic [SLOT_COUNT-1:0] members = '0;
        result_t               pending_results[$];
        int                    failures;

        function void report(string what);
            failures++;
            if (failures <= REPORT_MAX)
            begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                    logic [POS_W-1:0] hi);
            result_t r;
            int      i;
            int      top;
            r = '0;
            case (op)
                OP_SET:
                begin
                    if (pos < SPAN)
                        members[pos] = 1'b1;
                    else
                        r.error = 1'b1;
                end
                OP_CLEAR:
                begin
                    if (pos < SPAN)
                        members[pos] = 1'b0;
                end
                OP_TEST:
                begin
                    r.found = (pos < SPAN) && members[pos];
                end
                OP_FIRST:
                begin
                    for (i = 0; i < SPAN; i++)
                    begin
                        if (members[i])
                        begin
                            r.found = 1'b1;
                            r.found_position = POS_W'(i);
                            break;
                        end
                    end
                end
                OP_LAST:
                begin
                    for (i = SPAN - 1; i >= 0; i--)
                    begin
                        if (members[i])
                        begin
                            r.found = 1'b1;
                            r.found_position = POS_W'(i);
                            break;
                        end
                    end
                end
                OP_NEXT:
                begin
                    for (i = int'(pos) + 1; i < SPAN; i++)
                    begin
                        if (members[i])
                        begin
                            r.found = 1'b1;
                            r.found_position = POS_W'(i);
                            break;
                        end
                    end
                end
                OP_COUNT:
                begin
                    for (i = 0; i < SPAN; i++)
                        r.population += POP_W'(members[i]);
                end
                OP_RANGE:
                begin
                    if (pos <= hi)
                    begin
                        top = (int'(hi) < SPAN) ? int'(hi) : SPAN - 1;
                        for (i = int'(pos); i <= top; i++)
                        begin
                            if (members[i])
                            begin
                                r.found = 1'b1;
                                break;
                            end
                        end
                    end
                end
                OP_CLEARALL:
                begin
                    members = '0;
                end
                OP_INVERT:
                begin
                    if (pos < SPAN)
                    begin
                        for (i = 0; i <= int'(pos); i++)
                            members[i] = ~members[i];
                    end
                    else
                    begin
                        r.error = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_response(logic f, logic [POS_W-1:0] fpos,
                                     logic [POP_W-1:0] pop, logic err);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("response beat with nothing expected: found=%0b pos=%0d pop=%0d err=%0b",
                                 f, fpos, pop, err));
                return;
            end
            want = pending_results.pop_front();
            if (f !== want.found || fpos !== want.found_position ||
                pop !== want.population || err !== want.error)
            begin
                report($sformatf("mismatch: expected found=%0b pos=%0d pop=%0d err=%0b, got found=%0b pos=%0d pop=%0d err=%0b",
                                 want.found, want.found_position, want.population, want.error,
                                 f, fpos, pop, err));
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] range_end;
    logic             rsp_valid;
    logic             rsp_ready;
    logic             found;
    logic [POS_W-1:0] found_position;
    logic [POP_W-1:0] population;
    logic             error;

    bitset_tracker    tracker;
    int               burst_left;
    bit               idle_enabled;
    logic [POS_W-1:0] focus;

    bit_vector_set_engine_core #(
        .CAPACITY(DEFAULT_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .opcode(opcode),
        .position(position),
        .range_end(range_end),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .found(found),
        .found_position(found_position),
        .population(population),
        .error(error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            tracker.apply_request(opcode, position, range_end);
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_response(found, found_position, population, error);
    end

    // response stall: rotating mask, reloaded with a new pattern after a random hold
    initial
    begin : receiver
        logic [7:0] stall_mask;
        int         hold;
        stall_mask = 8'hFF;
        hold = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_mask = 8'hFF;
                    1: stall_mask = 8'($urandom) | 8'h01;
                    2: stall_mask = 8'h01;
                    default: stall_mask = 8'hB6;
                endcase
                hold = $urandom_range(20, 150);
            end
            hold--;
            rsp_ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[7:1]};
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [POS_W-1:0] hi);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (idle_enabled)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        position  <= pos;
        range_end <= hi;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return POS_W'(1);
                2: return POS_W'(POS_TOP - 1);
                default: return POS_W'(POS_TOP);
            endcase
        end
        else if (sel < 5)
        begin
            return focus + POS_W'($urandom_range(0, 7)) - POS_W'(3);
        end
        return POS_W'($urandom_range(0, POS_TOP));
    endfunction

    function automatic logic [POS_W-1:0] pick_range_end(logic [POS_W-1:0] pos);
        int sel;
        int hi;
        sel = $urandom_range(0, 19);
        if (sel < 10)
        begin
            hi = int'(pos) + $urandom_range(0, 15);
            return POS_W'((hi > POS_TOP) ? POS_TOP : hi);
        end
        else if (sel < 15)
        begin
            return POS_W'($urandom_range(0, POS_TOP));
        end
        else if (sel < 18)
        begin
            return POS_W'(POS_TOP);
        end
        return POS_W'((int'(pos) > 0) ? $urandom_range(0, int'(pos) - 1) : 0);
    endfunction

    task automatic random_request();
        int               sel;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        sel = $urandom_range(0, 99);
        if (sel < 22)
            op = OP_SET;
        else if (sel < 32)
            op = OP_CLEAR;
        else if (sel < 44)
            op = OP_TEST;
        else if (sel < 51)
            op = OP_FIRST;
        else if (sel < 58)
            op = OP_LAST;
        else if (sel < 70)
            op = OP_NEXT;
        else if (sel < 76)
            op = OP_COUNT;
        else if (sel < 87)
            op = OP_RANGE;
        else if (sel < 89)
            op = OP_CLEARALL;
        else if (sel < 96)
            op = OP_INVERT;
        else
            op = OP_W'($urandom_range(int'(OP_INVERT) + 1, OP_TOP));
        pos = pick_position();
        send_request(op, pos, pick_range_end(pos));
    endtask

    task automatic directed_requests();
        send_request(OP_FIRST, '0, '0);
        send_request(OP_LAST, '0, '0);
        send_request(OP_COUNT, '0, '0);
        send_request(OP_NEXT, POS_W'(POS_TOP), '0);
        send_request(OP_SET, '0, '0);
        send_request(OP_SET, POS_W'(POS_TOP), '0);
        send_request(OP_SET, POS_W'(128), '0);
        send_request(OP_TEST, POS_W'(POS_TOP), '0);
        send_request(OP_TEST, POS_W'(1), '0);
        send_request(OP_FIRST, '0, '0);
        send_request(OP_LAST, '0, '0);
        send_request(OP_NEXT, '0, '0);
        send_request(OP_NEXT, POS_W'(128), '0);
        send_request(OP_NEXT, POS_W'(POS_TOP), '0);
        send_request(OP_COUNT, '0, '0);
        send_request(OP_RANGE, POS_W'(1), POS_W'(127));
        send_request(OP_RANGE, POS_W'(100), POS_W'(200));
        send_request(OP_RANGE, POS_W'(200), POS_W'(100));
        send_request(OP_CLEAR, POS_W'(128), '0);
        send_request(OP_INVERT, POS_W'(POS_TOP), '0);
        send_request(OP_COUNT, '0, '0);
        send_request(OP_INVERT, '0, '0);
        send_request(OP_CLEARALL, POS_W'(POS_TOP), POS_W'(POS_TOP));
        send_request(OP_W'(OP_TOP), POS_W'(POS_TOP), POS_W'(POS_TOP));
        send_request(OP_W'(int'(OP_INVERT) + 1), '0, '0);
    endtask

    initial
    begin
        tracker      = new();
        burst_left   = 0;
        idle_enabled = 1'b0;
        focus        = '0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        opcode       = '0;
        position     = '0;
        range_end    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_requests();
        for (int n = 0; n < RANDOM_REQ; n++)
        begin
            if (n % 200 == 0)
                idle_enabled = ($urandom_range(0, 3) != 0);
            if (n % 50 == 0)
                focus = POS_W'($urandom_range(0, POS_TOP));
            random_request();
        end
        req_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
